// ----- hw/rtl/jddm_pkg.sv -----
// Shared widths, constants and types for the joystick differential drive mixer.
// No dependencies; every other file of the block imports this package.
package jddm_pkg;

  localparam int PW   = 16;  // pulse width field
  localparam int DBW  = 11;  // deadband register
  localparam int DW   = 12;  // duty field
  localparam int QW   = 18;  // scaled magnitude before offset
  localparam int CW   = 20;  // signed coordinate and coordinate sums
  localparam int RW   = 26;  // reciprocal constant
  localparam int IDXW = 2;   // config register index

  localparam logic [IDXW-1:0] REG_DEADBAND  = 2'd0;
  localparam logic [IDXW-1:0] REG_VALID_MIN = 2'd1;
  localparam logic [IDXW-1:0] REG_VALID_MAX = 2'd2;

  localparam logic [DBW-1:0] DEADBAND_RST  = 11'd20;
  localparam logic [PW-1:0]  VALID_MIN_RST = 16'd900;
  localparam logic [PW-1:0]  VALID_MAX_RST = 16'd2100;

  localparam logic [PW-1:0] PULSE_CENTER = 16'd1500;
  localparam logic [PW-1:0] PULSE_ZERO   = 16'd1000;

  // 31/10 scale as a multiply by ceil(2^24 * 31 / 10) and a shift by 24
  localparam logic [RW-1:0] SCALE_RECIP = 26'd52009370;
  localparam int            SCALE_SHIFT = 24;

  localparam logic signed [CW-1:0] COORD_OFFSET = 20'sd1550;
  localparam logic [DW-1:0]        DUTY_MAX     = 12'd3720;

  typedef struct packed {
    logic [DBW-1:0] deadband;
    logic [PW-1:0]  valid_min;
    logic [PW-1:0]  valid_max;
  } cfg_t;

  typedef struct packed {
    logic          x_neg;
    logic [QW-1:0] x_mag;
    logic          y_neg;
    logic [QW-1:0] y_mag;
    logic          failsafe;
  } coord_t;

endpackage

// ----- hw/rtl/joystick_differential_drive_mixer.sv -----
// Arcade drive mixer for a two-motor differential drive.
//
// Input channel: in_valid / in_stall with pulse_x (steering) and pulse_y
// (throttle), pulse widths in microseconds. An item is taken at a clock edge
// with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with left_duty, right_duty, the four
// bridge enables and failsafe_active; one result for every input item, in order.
// Config port: cfg_we, cfg_index (0 deadband, 1 valid_min, 2 valid_max),
// cfg_data; the user must write it only while the block is idle; the block
// does not enforce this. Other indexes are ignored. The accepting edge loads
// the input register, then the scaled coordinate register, then the result
// register. Throughput is one item per cycle while the receiver does not stall;
// the stage between input and coordinate registers holds the 16x26 multiply.
// When the receiver stalls, the result register holds and the pipeline fills;
// in_stall rises once every stage holds an item.
// Reset clears all valids, restores the config defaults and clears the held
// duties and directions, which repeat when a coordinate is exactly zero.
// Depends on jddm_pkg, jddm_cfg, jddm_scale and jddm_mix.
module joystick_differential_drive_mixer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [jddm_pkg::IDXW-1:0]  cfg_index,
  input  logic [jddm_pkg::PW-1:0]    cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [jddm_pkg::PW-1:0]    pulse_x,
  input  logic [jddm_pkg::PW-1:0]    pulse_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [jddm_pkg::DW-1:0]    left_duty,
  output logic [jddm_pkg::DW-1:0]    right_duty,
  output logic                       left_fwd,
  output logic                       left_rev,
  output logic                       right_fwd,
  output logic                       right_rev,
  output logic                       failsafe_active
);
  import jddm_pkg::*;

  cfg_t   cfg;
  coord_t coord;
  logic   c_valid;
  logic   c_stall;

  jddm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jddm_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pulse_x  (pulse_x),
    .pulse_y  (pulse_y),
    .c_valid  (c_valid),
    .c_stall  (c_stall),
    .coord    (coord)
  );

  jddm_mix u_mix (
    .clk             (clk),
    .rst             (rst),
    .deadband        (cfg.deadband),
    .c_valid         (c_valid),
    .c_stall         (c_stall),
    .coord           (coord),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .left_duty       (left_duty),
    .right_duty      (right_duty),
    .left_fwd        (left_fwd),
    .left_rev        (left_rev),
    .right_fwd       (right_fwd),
    .right_rev       (right_rev),
    .failsafe_active (failsafe_active)
  );

endmodule

// ----- hw/rtl/jddm_cfg.sv -----
// Configuration registers of the mixer: deadband and pulse validity window.
// Depends on jddm_pkg.
module jddm_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [jddm_pkg::IDXW-1:0]  cfg_index,
  input  logic [jddm_pkg::PW-1:0]    cfg_data,
  output jddm_pkg::cfg_t             cfg
);
  import jddm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband  <= DEADBAND_RST;
      cfg.valid_min <= VALID_MIN_RST;
      cfg.valid_max <= VALID_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEADBAND:  cfg.deadband  <= cfg_data[DBW-1:0];
        REG_VALID_MIN: cfg.valid_min <= cfg_data;
        REG_VALID_MAX: cfg.valid_max <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/jddm_scale.sv -----
// Input register, fail-safe substitution and pulse-to-coordinate scaling.
// Depends on jddm_pkg; feeds jddm_mix through a registered coord_t.
module jddm_scale (
  input  logic                    clk,
  input  logic                    rst,
  input  jddm_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [jddm_pkg::PW-1:0] pulse_x,
  input  logic [jddm_pkg::PW-1:0] pulse_y,
  output logic                    c_valid,
  input  logic                    c_stall,
  output jddm_pkg::coord_t        coord
);
  import jddm_pkg::*;

  logic          v1;
  logic [PW-1:0] px;
  logic [PW-1:0] py;
  logic          ready1;
  logic          ready2;
  logic          fs;
  logic [PW-1:0] sx;
  logic [PW-1:0] sy;
  logic          x_neg;
  logic          y_neg;
  logic [PW-1:0] x_mag;
  logic [PW-1:0] y_mag;
  logic [PW+RW-1:0] prod_x;
  logic [PW+RW-1:0] prod_y;
  coord_t        coord_next;

  assign ready2   = !c_valid || !c_stall;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      px <= pulse_x;
      py <= pulse_y;
    end
  end

  always_comb begin
    fs = (px < cfg.valid_min) || (py < cfg.valid_min) ||
         (px > cfg.valid_max) || (py > cfg.valid_max);
    sx = fs ? PULSE_CENTER : px;
    sy = fs ? PULSE_CENTER : py;
    x_neg = sx < PULSE_ZERO;
    y_neg = sy < PULSE_ZERO;
    x_mag = x_neg ? (PULSE_ZERO - sx) : (sx - PULSE_ZERO);
    y_mag = y_neg ? (PULSE_ZERO - sy) : (sy - PULSE_ZERO);
    prod_x = (PW+RW)'(x_mag) * (PW+RW)'(SCALE_RECIP);
    prod_y = (PW+RW)'(y_mag) * (PW+RW)'(SCALE_RECIP);
    coord_next.x_neg    = x_neg;
    coord_next.x_mag    = prod_x[SCALE_SHIFT +: QW];
    coord_next.y_neg    = y_neg;
    coord_next.y_mag    = prod_y[SCALE_SHIFT +: QW];
    coord_next.failsafe = fs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (ready2) begin
      c_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      coord <= coord_next;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1)
    else $error("input stalled with empty input register");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && !ready2) |=> (v1 && $stable(px) && $stable(py)))
    else $error("held input item lost or changed");

  a_failsafe_centered: assert property (@(posedge clk) disable iff (rst)
    (ready2 && v1 && fs) |=> (coord.failsafe && !coord.x_neg && !coord.y_neg &&
                              coord.x_mag == coord.y_mag))
    else $error("fail-safe item not centered");
`endif

endmodule

// ----- hw/rtl/jddm_mix.sv -----
// Deadband test, octant mixing, duty clamp and the result register that also
// holds the last duties and bridge directions. Depends on jddm_pkg.
module jddm_mix (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [jddm_pkg::DBW-1:0] deadband,
  input  logic                     c_valid,
  output logic                     c_stall,
  input  jddm_pkg::coord_t         coord,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [jddm_pkg::DW-1:0]  left_duty,
  output logic [jddm_pkg::DW-1:0]  right_duty,
  output logic                     left_fwd,
  output logic                     left_rev,
  output logic                     right_fwd,
  output logic                     right_rev,
  output logic                     failsafe_active
);
  import jddm_pkg::*;

  typedef struct packed {
    logic left_fwd;
    logic left_rev;
    logic right_fwd;
    logic right_rev;
  } dir_t;

  function automatic logic [DW-1:0] clamp_duty(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] a;
    a = (v < 0) ? -v : v;
    return (a > $signed(CW'(DUTY_MAX))) ? DUTY_MAX : a[DW-1:0];
  endfunction

  logic                 ready3;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic signed [CW-1:0] sum;
  logic signed [CW-1:0] db;
  logic [DW-1:0]        d_sum;
  logic [DW-1:0]        d_diff;
  logic [DW-1:0]        d_x;
  logic [DW-1:0]        d_y;
  logic                 hit;
  logic [DW-1:0]        left_next;
  logic [DW-1:0]        right_next;
  dir_t                 dir_next;
  dir_t                 dirs;

  assign ready3  = !out_valid || !out_stall;
  assign c_stall = !ready3;

  always_comb begin
    x   = coord.x_neg ? (-$signed(CW'(coord.x_mag)) - COORD_OFFSET)
                      : ($signed(CW'(coord.x_mag)) - COORD_OFFSET);
    y   = coord.y_neg ? (-$signed(CW'(coord.y_mag)) - COORD_OFFSET)
                      : ($signed(CW'(coord.y_mag)) - COORD_OFFSET);
    ax  = (x < 0) ? -x : x;
    ay  = (y < 0) ? -y : y;
    sum = x + y;
    db  = $signed(CW'(deadband));
    d_sum  = clamp_duty(sum);
    d_diff = clamp_duty(y - x);
    d_x    = clamp_duty(x);
    d_y    = clamp_duty(y);
    hit        = 1'b1;
    left_next  = '0;
    right_next = '0;
    dir_next   = '0;
    if (ax < db && ay < db) begin
      hit = 1'b1;
    end else if (x < 0 && y < 0) begin
      if (x >= y) begin
        left_next = d_diff; right_next = d_y;
        dir_next.left_rev = 1'b1; dir_next.right_rev = 1'b1;
      end else begin
        left_next = d_diff; right_next = d_diff;
        dir_next.left_rev = 1'b1; dir_next.right_fwd = 1'b1;
      end
    end else if (x < 0 && y > 0) begin
      if (sum >= 0) begin
        left_next = d_sum; right_next = d_y;
        dir_next.left_fwd = 1'b1; dir_next.right_fwd = 1'b1;
      end else begin
        left_next = d_sum; right_next = d_x;
        dir_next.left_rev = 1'b1; dir_next.right_fwd = 1'b1;
      end
    end else if (x > 0 && y < 0) begin
      if (sum <= 0) begin
        left_next = d_y; right_next = d_sum;
        dir_next.left_rev = 1'b1; dir_next.right_rev = 1'b1;
      end else begin
        left_next = d_sum; right_next = d_sum;
        dir_next.left_fwd = 1'b1; dir_next.right_rev = 1'b1;
      end
    end else if (x > 0 && y > 0) begin
      if (y >= x) begin
        left_next = d_y; right_next = d_diff;
        dir_next.left_fwd = 1'b1; dir_next.right_fwd = 1'b1;
      end else begin
        left_next = d_x; right_next = d_diff;
        dir_next.left_fwd = 1'b1; dir_next.right_rev = 1'b1;
      end
    end else begin
      hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      left_duty  <= '0;
      right_duty <= '0;
      dirs       <= '0;
    end else begin
      if (ready3) begin
        out_valid <= c_valid;
      end
      if (ready3 && c_valid && hit) begin
        left_duty  <= left_next;
        right_duty <= right_next;
        dirs       <= dir_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && c_valid) begin
      failsafe_active <= coord.failsafe;
    end
  end

  assign left_fwd  = dirs.left_fwd;
  assign left_rev  = dirs.left_rev;
  assign right_fwd = dirs.right_fwd;
  assign right_rev = dirs.right_rev;

`ifndef ASSERT_OFF
  a_bridge_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(dirs.left_fwd && dirs.left_rev) && !(dirs.right_fwd && dirs.right_rev))
    else $error("bridge driven both ways");

  a_off_means_zero: assert property (@(posedge clk) disable iff (rst)
    (dirs == '0) |-> (left_duty == '0 && right_duty == '0))
    else $error("duty without direction");

  a_failsafe_stops: assert property (@(posedge clk) disable iff (rst)
    (ready3 && c_valid && coord.failsafe && deadband != '0) |=>
      (left_duty == '0 && right_duty == '0 && failsafe_active))
    else $error("fail-safe item did not stop motors");
`endif

endmodule

// ----- tb/jddm_mix_checker.sv -----
`timescale 1ns / 100ps
// Checker for the joystick differential drive mixer: watches the config port and both
// channels, predicts every drive command and compares it with the block's result items.
// Depends on jddm_pkg for widths, register indexes and mixer constants.
module jddm_mix_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [jddm_pkg::IDXW-1:0] cfg_index,
  input  logic [jddm_pkg::PW-1:0]   cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [jddm_pkg::PW-1:0]   pulse_x,
  input  logic [jddm_pkg::PW-1:0]   pulse_y,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [jddm_pkg::DW-1:0]   left_duty,
  input  logic [jddm_pkg::DW-1:0]   right_duty,
  input  logic                      left_fwd,
  input  logic                      left_rev,
  input  logic                      right_fwd,
  input  logic                      right_rev,
  input  logic                      failsafe_active,
  output int                        fail_count,
  output int                        outstanding
);
  import jddm_pkg::*;

  localparam logic [3:0] DIR_LF = 4'b0001;
  localparam logic [3:0] DIR_LR = 4'b0010;
  localparam logic [3:0] DIR_RF = 4'b0100;
  localparam logic [3:0] DIR_RR = 4'b1000;

  typedef struct packed {
    logic [DW-1:0] left_duty;
    logic [DW-1:0] right_duty;
    logic          left_fwd;
    logic          left_rev;
    logic          right_fwd;
    logic          right_rev;
    logic          failsafe;
  } drive_cmd_t;

  logic [DBW-1:0] cfg_deadband;
  logic [PW-1:0]  cfg_min;
  logic [PW-1:0]  cfg_max;
  logic [DW-1:0]  hold_left;
  logic [DW-1:0]  hold_right;
  logic [3:0]     hold_dir;

  drive_cmd_t expected_cmds[$];
  drive_cmd_t want;
  int         mismatches = 0;

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [DW-1:0] duty_limit(int v);
    v = abs_int(v);
    if (v > int'(DUTY_MAX)) v = int'(DUTY_MAX);
    return v[DW-1:0];
  endfunction

  function automatic int pulse_to_coord(logic [PW-1:0] p);
    int d;
    d = int'(p) - int'(PULSE_ZERO);
    return (d * 3100) / 1000 - int'(COORD_OFFSET);
  endfunction

  function automatic drive_cmd_t mix_command(logic [PW-1:0] px, logic [PW-1:0] py);
    drive_cmd_t cmd;
    logic       fs;
    logic       hit;
    logic [3:0] dir;
    int         x;
    int         y;
    int         l;
    int         r;
    fs  = 1'b0;
    hit = 1'b1;
    dir = '0;
    l   = 0;
    r   = 0;
    if (px < cfg_min || py < cfg_min || px > cfg_max || py > cfg_max) begin
      px = PULSE_CENTER;
      py = PULSE_CENTER;
      fs = 1'b1;
    end
    x = pulse_to_coord(px);
    y = pulse_to_coord(py);
    if (abs_int(x) < int'(cfg_deadband) && abs_int(y) < int'(cfg_deadband)) begin
      dir = '0;
    end else if (x < 0 && y < 0) begin
      if (x >= y) begin
        l = y - x; r = y; dir = DIR_LR | DIR_RR;
      end else begin
        l = x - y; r = y - x; dir = DIR_LR | DIR_RF;
      end
    end else if (x < 0 && y > 0) begin
      if (y >= -x) begin
        l = y + x; r = y; dir = DIR_LF | DIR_RF;
      end else begin
        l = y + x; r = -x; dir = DIR_LR | DIR_RF;
      end
    end else if (x > 0 && y < 0) begin
      if (-y >= x) begin
        l = y; r = y + x; dir = DIR_LR | DIR_RR;
      end else begin
        l = x + y; r = x + y; dir = DIR_LF | DIR_RR;
      end
    end else if (x > 0 && y > 0) begin
      if (y >= x) begin
        l = y; r = y - x; dir = DIR_LF | DIR_RF;
      end else begin
        l = x; r = y - x; dir = DIR_LF | DIR_RR;
      end
    end else begin
      hit = 1'b0;
    end
    if (hit) begin
      hold_left  = duty_limit(l);
      hold_right = duty_limit(r);
      hold_dir   = dir;
    end
    cmd.left_duty  = hold_left;
    cmd.right_duty = hold_right;
    cmd.left_fwd   = |(hold_dir & DIR_LF);
    cmd.left_rev   = |(hold_dir & DIR_LR);
    cmd.right_fwd  = |(hold_dir & DIR_RF);
    cmd.right_rev  = |(hold_dir & DIR_RR);
    cmd.failsafe   = fs;
    return cmd;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_deadband = DEADBAND_RST;
      cfg_min      = VALID_MIN_RST;
      cfg_max      = VALID_MAX_RST;
      hold_left    = '0;
      hold_right   = '0;
      hold_dir     = '0;
      expected_cmds.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $error("result item with no pending drive command");
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("left_duty", int'(want.left_duty), int'(left_duty));
          check_field("right_duty", int'(want.right_duty), int'(right_duty));
          check_field("left_fwd", int'(want.left_fwd), int'(left_fwd));
          check_field("left_rev", int'(want.left_rev), int'(left_rev));
          check_field("right_fwd", int'(want.right_fwd), int'(right_fwd));
          check_field("right_rev", int'(want.right_rev), int'(right_rev));
          check_field("failsafe_active", int'(want.failsafe), int'(failsafe_active));
        end
      end
      if (in_valid && !in_stall) expected_cmds.push_back(mix_command(pulse_x, pulse_y));
      if (cfg_we) begin
        case (cfg_index)
          REG_DEADBAND:  cfg_deadband = cfg_data[DBW-1:0];
          REG_VALID_MIN: cfg_min = cfg_data;
          REG_VALID_MAX: cfg_max = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= expected_cmds.size();
    fail_count  <= mismatches;
  end

endmodule

// ----- tb/joystick_differential_drive_mixer_tb.sv -----
`timescale 1ns / 100ps
// Top of the mixer testbench: clock, reset, register settings, pulse stimulus and
// receiver stalls, with the verdict. Depends on jddm_pkg, the mixer and jddm_mix_checker.
module joystick_differential_drive_mixer_tb;
  import jddm_pkg::*;

  localparam logic [IDXW-1:0] REG_NONE = 2'd3;
  localparam int MAX_WAIT  = 12;
  localparam int LONG_HOLD = 60;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [IDXW-1:0] cfg_index = '0;
  logic [PW-1:0]   cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [PW-1:0]   pulse_x = '0;
  logic [PW-1:0]   pulse_y = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [DW-1:0]   left_duty;
  logic [DW-1:0]   right_duty;
  logic            left_fwd;
  logic            left_rev;
  logic            right_fwd;
  logic            right_rev;
  logic            failsafe_active;
  int              fail_count;
  int              outstanding;

  int cur_min = int'(VALID_MIN_RST);
  int cur_max = int'(VALID_MAX_RST);
  bit steady  = 1'b0;

  joystick_differential_drive_mixer i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .pulse_x, .pulse_y,
    .out_valid, .out_stall, .left_duty, .right_duty,
    .left_fwd, .left_rev, .right_fwd, .right_rev, .failsafe_active
  );

  jddm_mix_checker i_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .pulse_x, .pulse_y,
    .out_valid, .out_stall, .left_duty, .right_duty,
    .left_fwd, .left_rev, .right_fwd, .right_rev, .failsafe_active,
    .fail_count, .outstanding
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4ms;
    $display("joystick_differential_drive_mixer_tb failed");
    $finish;
  end

  // receiver: per-item stall, occasional eager stretches, two long hold-offs
  initial begin : receiver
    int hold;
    int taken;
    bit eager;
    hold  = 0;
    taken = 0;
    eager = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        taken++;
        if (taken % 100 == 0) eager = ($urandom_range(0, 3) == 0);
        if (taken == 300 || taken == 1200) hold = LONG_HOLD;
        else hold = eager ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_pulses(input logic [PW-1:0] px, input logic [PW-1:0] py);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pulse_x  <= px;
    pulse_y  <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [PW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [PW-1:0] db, input logic [PW-1:0] vmin,
                              input logic [PW-1:0] vmax);
    drain();
    write_reg(REG_DEADBAND, db);
    write_reg(REG_VALID_MIN, vmin);
    write_reg(REG_VALID_MAX, vmax);
    cur_min = int'(vmin);
    cur_max = int'(vmax);
  endtask

  function automatic logic [PW-1:0] pick_pulse();
    int kind;
    int pick;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 4, 5: pick = $urandom_range(cur_max, cur_min);
      6: pick = 1490 + $urandom_range(0, 20);
      7: pick = int'(PULSE_CENTER);
      8: begin
        case ($urandom_range(0, 3))
          0: pick = cur_min - 1;
          1: pick = cur_min;
          2: pick = cur_max;
          default: pick = cur_max + 1;
        endcase
      end
      default: pick = $urandom();
    endcase
    return pick[PW-1:0];
  endfunction

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      send_pulses(pick_pulse(), pick_pulse());
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // centered, window edges, fail-safe both sides
    send_pulses(16'd1500, 16'd1500);
    send_pulses(16'd900, 16'd900);
    send_pulses(16'd2100, 16'd2100);
    send_pulses(16'd900, 16'd2100);
    send_pulses(16'd2100, 16'd900);
    send_pulses(16'd899, 16'd1500);
    send_pulses(16'd1500, 16'd2101);
    send_pulses(16'd0, 16'd0);
    send_pulses(16'hFFFF, 16'hFFFF);
    // one item per octant
    send_pulses(16'd1200, 16'd1100);
    send_pulses(16'd1100, 16'd1200);
    send_pulses(16'd1400, 16'd1800);
    send_pulses(16'd1100, 16'd1600);
    send_pulses(16'd1600, 16'd1100);
    send_pulses(16'd1900, 16'd1400);
    send_pulses(16'd1600, 16'd1900);
    send_pulses(16'd1900, 16'd1600);
    // zero coordinate holds, deadband edge
    send_pulses(16'd1500, 16'd1800);
    send_pulses(16'd1800, 16'd1500);
    send_pulses(16'd1506, 16'd1500);
    send_pulses(16'd1507, 16'd1500);
    run_random(350);

    // open window, no deadband: saturation and zero-coordinate hold
    load_setting(16'd0, 16'd0, 16'hFFFF);
    send_pulses(16'hFFFF, 16'd1000);
    send_pulses(16'd0, 16'hFFFF);
    send_pulses(16'd1500, 16'd1500);
    run_random(250);

    load_setting(16'd1860, 16'd900, 16'd2100);
    run_random(150);

    repeat (4) begin
      load_setting(PW'($urandom_range(0, 300)), PW'($urandom_range(500, 1100)),
                   PW'($urandom_range(1900, 2600)));
      run_random(150);
    end

    // inverted window
    load_setting(16'd20, 16'd2000, 16'd1000);
    run_random(80);

    // upper deadband bits dropped; unused index ignored
    load_setting(16'hFFFF, 16'd0, 16'hFFFF);
    write_reg(REG_NONE, 16'hFFFF);
    run_random(150);

    load_setting(16'd0, 16'd1500, 16'd1500);
    run_random(80);

    load_setting(PW'(DEADBAND_RST), VALID_MIN_RST, VALID_MAX_RST);
    run_random(200);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("joystick_differential_drive_mixer_tb passed");
    end else begin
      $display("joystick_differential_drive_mixer_tb failed");
    end
    $finish;
  end

endmodule

// ----- joystick_differential_drive_mixer.f -----
hw/rtl/jddm_pkg.sv
hw/rtl/jddm_cfg.sv
hw/rtl/jddm_scale.sv
hw/rtl/jddm_mix.sv
hw/rtl/joystick_differential_drive_mixer.sv
tb/jddm_mix_checker.sv
tb/joystick_differential_drive_mixer_tb.sv
